// ===== src/mlrt_pkg.sv =====
// ----------------------------------------------------------------------------
// mlrt_pkg - shared types and constants of the label route table
// Field widths, operation and status codes and the result beat type.
// ----------------------------------------------------------------------------
package mlrt_pkg;

    // default sizes of the table
    localparam int unsigned ROUTES_DEF   = 64;
    localparam int unsigned HOPS_DEF     = 4;
    localparam int unsigned PROTOCOLS_DEF = 2;

    // fixed field widths
    localparam int unsigned LABEL_W = 20;
    localparam int unsigned ID_W    = 8;
    localparam int unsigned INTF_W  = 4;

    typedef enum logic [1:0] {
        KIND_INSTALL   = 2'd0,
        KIND_UNINSTALL = 2'd1,
        KIND_FORWARD   = 2'd2,
        KIND_NONE      = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_DUP        = 3'd1,
        ST_NO_ROUTE   = 3'd2,
        ST_NO_HOP     = 3'd3,
        ST_TABLE_FULL = 3'd4,
        ST_SLOTS_FULL = 3'd5,
        ST_NO_ACTIVE  = 3'd6
    } status_t;

    typedef struct packed {
        status_t             status;
        logic [ID_W-1:0]     hop;
        logic [INTF_W-1:0]   intf;
    } result_t;

endpackage

// ===== src/mlrt_out_reg.sv =====
// ----------------------------------------------------------------------------
// mlrt_out_reg - result output register
// Holds one result beat until the receiver takes it.
// ----------------------------------------------------------------------------
module mlrt_out_reg
    import mlrt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  result_t load_data,
    output logic    free,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t data
);

    logic    valid_reg;
    result_t data_reg;

    // room for a new beat when empty or being drained
    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign data      = data_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load && free)
        begin
            valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (load && free)
        begin
            data_reg <= load_data;
        end
    end

endmodule

// ===== src/mpls_label_route_table.sv =====
// ----------------------------------------------------------------------------
// mpls_label_route_table - label keyed route table with round robin next hops
// Install, uninstall and forward requests on one input channel, one result
// beat per request on the output channel.
// ----------------------------------------------------------------------------
// usage
//   input beat (in_valid/in_ready): kind, label, proto, next hop and arrival
//   interface fields; output beat (out_valid/out_ready): status, chosen next
//   hop and its interface. every input beat gives exactly one output beat.
//   one request is worked on at a time; in_ready is high only when idle.
//   the label search walks the route memory, a read and a check state per
//   route for up to ROUTES routes, then a decision state, then where needed
//   the slot walk, a read and a check state per slot (up to HOPS_PER_PROTO
//   slots for install/uninstall, up to PROTOCOLS*HOPS_PER_PROTO for
//   forward), then a finish state loads the output register. the route
//   memory read port sets the search time. the next request is taken in
//   the cycle after the result loads. reset clears the route valid bits at
//   once; no clearing pass is needed, so the block takes a request in the
//   first cycle after reset. a stalled receiver holds the result in the
//   output register; the next request is still taken and worked on, and
//   waits in the last state until the output register is free.
// ----------------------------------------------------------------------------
module mpls_label_route_table
    import mlrt_pkg::*;
#(
    parameter int unsigned ROUTES         = ROUTES_DEF,
    parameter int unsigned HOPS_PER_PROTO = HOPS_DEF,
    parameter int unsigned PROTOCOLS      = PROTOCOLS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         kind,
    input  logic [LABEL_W-1:0] label,
    input  logic               proto,
    input  logic [ID_W-1:0]    nexthop_id,
    input  logic [INTF_W-1:0]  nexthop_intf,
    input  logic [INTF_W-1:0]  arrival_intf,
    input  logic               arrival_intf_valid,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         status,
    output logic [ID_W-1:0]    chosen_nexthop,
    output logic [INTF_W-1:0]  chosen_intf
);

    localparam int unsigned SPR   = PROTOCOLS * HOPS_PER_PROTO;
    localparam int unsigned TOTAL = ROUTES * SPR;
    localparam int unsigned RW    = (ROUTES > 1) ? $clog2(ROUTES) : 1;
    localparam int unsigned HW    = (HOPS_PER_PROTO > 1) ? $clog2(HOPS_PER_PROTO) : 1;
    localparam int unsigned PW    = (PROTOCOLS > 1) ? $clog2(PROTOCOLS) : 1;
    localparam int unsigned MW    = (SPR > 1) ? $clog2(SPR) : 1;
    localparam int unsigned SAW   = (TOTAL > 1) ? $clog2(TOTAL) : 1;
    localparam int unsigned RE_W  = LABEL_W + HW + SPR;
    localparam int unsigned SE_W  = ID_W + INTF_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK_RD,
        S_LOOK_CHK,
        S_DECIDE,
        S_SLOT_RD,
        S_SLOT_CHK,
        S_FINISH
    } state_t;

    // state and request registers
    state_t              state_reg, state_next;
    kind_t               kind_reg;
    logic [LABEL_W-1:0]  label_reg;
    logic                proto_reg;
    logic [ID_W-1:0]     id_reg;
    logic [INTF_W-1:0]   nh_intf_reg;
    logic [INTF_W-1:0]   rx_reg;
    logic                rxv_reg;

    logic [ROUTES-1:0]   used_reg, used_next;
    logic [RW-1:0]       scan_reg, scan_next;
    logic                found_reg, found_next;
    logic [RW-1:0]       found_idx_reg, found_idx_next;
    logic                free_ok_reg, free_ok_next;
    logic [RW-1:0]       free_idx_reg, free_idx_next;
    logic [HW-1:0]       rot_reg, rot_next;
    logic [SPR-1:0]      mask_reg, mask_next;
    logic [HW-1:0]       k_reg, k_next;
    logic [PW-1:0]       p_reg, p_next;
    result_t             res_reg, res_next;

    // memories
    logic [RE_W-1:0]     route_mem [ROUTES];
    logic [RE_W-1:0]     r_rdata_reg;
    logic [RW-1:0]       r_raddr;
    logic                r_we;
    logic [RW-1:0]       r_waddr;
    logic [RE_W-1:0]     r_wdata;

    logic [SE_W-1:0]     slot_mem [TOTAL];
    logic [SE_W-1:0]     s_rdata_reg;
    logic [SAW-1:0]      s_raddr;
    logic                s_we;
    logic [SAW-1:0]      s_waddr;
    logic [SE_W-1:0]     s_wdata;

    // helpers
    logic                out_free;
    logic                out_load;
    logic                accept;
    logic [PW-1:0]       proto_p;
    logic                proto_bad;
    logic [HW:0]         wrap_sum;
    logic [HW-1:0]       hop_i;
    logic [PW-1:0]       walk_p;
    logic [MW-1:0]       bit_pos;
    logic [HW-1:0]       free_h;
    logic                free_h_ok;
    logic [LABEL_W-1:0]  rd_label;
    logic [ID_W-1:0]     rd_hop;
    logic [INTF_W-1:0]   rd_intf;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign proto_p   = PW'(proto_reg);
    assign proto_bad = (32'(proto_reg) >= PROTOCOLS);
    assign rd_label  = r_rdata_reg[RE_W-1 -: LABEL_W];
    assign rd_hop    = s_rdata_reg[SE_W-1 -: ID_W];
    assign rd_intf   = s_rdata_reg[INTF_W-1:0];

    // round robin hop position with wrap-around
    always_comb
    begin
        wrap_sum = {1'b0, rot_reg} + {1'b0, k_reg};
        if (32'(wrap_sum) >= HOPS_PER_PROTO)
        begin
            wrap_sum = wrap_sum - (HW+1)'(HOPS_PER_PROTO);
        end
    end

    assign hop_i   = (kind_reg == KIND_FORWARD) ? wrap_sum[HW-1:0] : k_reg;
    assign walk_p  = (kind_reg == KIND_FORWARD) ? p_reg : proto_p;
    assign bit_pos = MW'(walk_p * HOPS_PER_PROTO) + MW'(hop_i);
    assign s_raddr = SAW'(found_idx_reg) * SAW'(SPR) + SAW'(walk_p) * SAW'(HOPS_PER_PROTO)
                     + SAW'(hop_i);

    // lowest free slot of the request's protocol
    always_comb
    begin
        free_h    = '0;
        free_h_ok = 1'b0;
        for (int h = HOPS_PER_PROTO - 1; h >= 0; h--)
        begin
            if (!mask_reg[MW'(proto_p * HOPS_PER_PROTO) + MW'(h)])
            begin
                free_h    = HW'(h);
                free_h_ok = 1'b1;
            end
        end
    end

    // route memory
    always_ff @(posedge clk)
    begin
        if (r_we)
        begin
            route_mem[r_waddr] <= r_wdata;
        end
        r_rdata_reg <= route_mem[r_raddr];
    end

    // slot memory
    always_ff @(posedge clk)
    begin
        if (s_we)
        begin
            slot_mem[s_waddr] <= s_wdata;
        end
        s_rdata_reg <= slot_mem[s_raddr];
    end

    assign r_raddr = scan_reg;

    // next state, memory writes and results
    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        scan_next      = scan_reg;
        found_next     = found_reg;
        found_idx_next = found_idx_reg;
        free_ok_next   = free_ok_reg;
        free_idx_next  = free_idx_reg;
        rot_next       = rot_reg;
        mask_next      = mask_reg;
        k_next         = k_reg;
        p_next         = p_reg;
        res_next       = res_reg;
        r_we           = 1'b0;
        r_waddr        = found_idx_reg;
        r_wdata        = {label_reg, rot_reg, mask_reg};
        s_we           = 1'b0;
        s_waddr        = s_raddr;
        s_wdata        = {id_reg, nh_intf_reg};
        out_load       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    scan_next    = '0;
                    found_next   = 1'b0;
                    free_ok_next = 1'b0;
                    res_next     = '{status: ST_OK, hop: '0, intf: '0};
                    state_next   = (kind_t'(kind) == KIND_NONE) ? S_FINISH : S_LOOK_RD;
                end
            end

            S_LOOK_RD:
            begin
                state_next = S_LOOK_CHK;
            end

            // label compare, note the first free route on the way
            S_LOOK_CHK:
            begin
                if (!used_reg[scan_reg] && !free_ok_reg)
                begin
                    free_ok_next  = 1'b1;
                    free_idx_next = scan_reg;
                end
                if (used_reg[scan_reg] && rd_label == label_reg)
                begin
                    found_next     = 1'b1;
                    found_idx_next = scan_reg;
                    rot_next       = r_rdata_reg[SPR +: HW];
                    mask_next      = r_rdata_reg[SPR-1:0];
                    state_next     = S_DECIDE;
                end
                else if (32'(scan_reg) == ROUTES - 1)
                begin
                    state_next = S_DECIDE;
                end
                else
                begin
                    scan_next  = scan_reg + RW'(1);
                    state_next = S_LOOK_RD;
                end
            end

            S_DECIDE:
            begin
                k_next     = '0;
                p_next     = '0;
                state_next = S_FINISH;
                if (!found_reg)
                begin
                    if (kind_reg != KIND_INSTALL)
                    begin
                        res_next.status = ST_NO_ROUTE;
                    end
                    else if (proto_bad)
                    begin
                        res_next.status = ST_SLOTS_FULL;
                    end
                    else if (!free_ok_reg)
                    begin
                        res_next.status = ST_TABLE_FULL;
                    end
                    else
                    begin
                        // new route with the hop in slot 0 of its protocol
                        used_next[free_idx_reg] = 1'b1;
                        mask_next                = '0;
                        mask_next[MW'(proto_p * HOPS_PER_PROTO)] = 1'b1;
                        r_we    = 1'b1;
                        r_waddr = free_idx_reg;
                        r_wdata = {label_reg, HW'(0), mask_next};
                        s_we    = 1'b1;
                        s_waddr = SAW'(free_idx_reg) * SAW'(SPR)
                                  + SAW'(proto_p) * SAW'(HOPS_PER_PROTO);
                    end
                end
                else if (proto_bad && kind_reg != KIND_FORWARD)
                begin
                    res_next.status = (kind_reg == KIND_INSTALL) ? ST_SLOTS_FULL : ST_NO_HOP;
                end
                else
                begin
                    state_next = S_SLOT_RD;
                end
            end

            S_SLOT_RD:
            begin
                state_next = S_SLOT_CHK;
            end

            S_SLOT_CHK:
            begin
                state_next = S_SLOT_RD;
                case (kind_reg)
                    KIND_INSTALL:
                    begin
                        if (mask_reg[bit_pos] && rd_hop == id_reg)
                        begin
                            res_next.status = ST_DUP;
                            state_next      = S_FINISH;
                        end
                        else if (32'(k_reg) == HOPS_PER_PROTO - 1)
                        begin
                            state_next = S_FINISH;
                            if (!free_h_ok)
                            begin
                                res_next.status = ST_SLOTS_FULL;
                            end
                            else
                            begin
                                mask_next = mask_reg;
                                mask_next[MW'(proto_p * HOPS_PER_PROTO) + MW'(free_h)] = 1'b1;
                                r_we    = 1'b1;
                                r_wdata = {label_reg, rot_reg, mask_next};
                                s_we    = 1'b1;
                                s_waddr = SAW'(found_idx_reg) * SAW'(SPR)
                                          + SAW'(proto_p) * SAW'(HOPS_PER_PROTO)
                                          + SAW'(free_h);
                            end
                        end
                        else
                        begin
                            k_next = k_reg + HW'(1);
                        end
                    end

                    KIND_UNINSTALL:
                    begin
                        if (mask_reg[bit_pos] && rd_hop == id_reg)
                        begin
                            mask_next          = mask_reg;
                            mask_next[bit_pos] = 1'b0;
                            r_we       = 1'b1;
                            r_wdata    = {label_reg, rot_reg, mask_next};
                            state_next = S_FINISH;
                            if (mask_next == '0)
                            begin
                                used_next[found_idx_reg] = 1'b0;
                            end
                        end
                        else if (32'(k_reg) == HOPS_PER_PROTO - 1)
                        begin
                            res_next.status = ST_NO_HOP;
                            state_next      = S_FINISH;
                        end
                        else
                        begin
                            k_next = k_reg + HW'(1);
                        end
                    end

                    KIND_FORWARD:
                    begin
                        if (mask_reg[bit_pos] && !(rxv_reg && rd_intf == rx_reg))
                        begin
                            rot_next = (32'(hop_i) == HOPS_PER_PROTO - 1) ? '0
                                                                        : hop_i + HW'(1);
                            r_we       = 1'b1;
                            r_wdata    = {label_reg, rot_next, mask_reg};
                            res_next   = '{status: ST_OK, hop: rd_hop, intf: rd_intf};
                            state_next = S_FINISH;
                        end
                        else if (32'(k_reg) == HOPS_PER_PROTO - 1)
                        begin
                            k_next = '0;
                            if (32'(p_reg) == PROTOCOLS - 1)
                            begin
                                res_next.status = ST_NO_ACTIVE;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                p_next = p_reg + PW'(1);
                            end
                        end
                        else
                        begin
                            k_next = k_reg + HW'(1);
                        end
                    end

                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end

            // hand the result to the output register
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            used_reg  <= '0;
            found_reg <= 1'b0;
            free_ok_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            found_reg   <= found_next;
            free_ok_reg <= free_ok_next;
        end
    end

    // payload and walk registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= kind_t'(kind);
            label_reg   <= label;
            proto_reg   <= proto;
            id_reg      <= nexthop_id;
            nh_intf_reg <= nexthop_intf;
            rx_reg      <= arrival_intf;
            rxv_reg     <= arrival_intf_valid;
        end
        scan_reg      <= scan_next;
        found_idx_reg <= found_idx_next;
        free_idx_reg  <= free_idx_next;
        rot_reg       <= rot_next;
        mask_reg      <= mask_next;
        k_reg         <= k_next;
        p_reg         <= p_next;
        res_reg       <= res_next;
    end

    // output stage
    result_t out_data;

    mlrt_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (out_load),
        .load_data (res_reg),
        .free      (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .data      (out_data)
    );

    assign status         = out_data.status;
    assign chosen_nexthop = out_data.hop;
    assign chosen_intf    = out_data.intf;

endmodule
